[hw/rtl/tilp_pkg.sv]
package tilp_pkg;

  localparam int TILP_NUM_TAGS   = 32;
  localparam int TILP_COUNT_BITS = 32;

  // ln2 in Q32 and the saturated magnitude of the log
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [21:0] LOG_MIN = 22'd2097152;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  localparam int FRAC_BITS   = 20;
  localparam int LAMBDA_BITS = 17;
  localparam int MAG_BITS    = 26;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_ZERO_PROB   = 2'd1;
  localparam logic [1:0] ST_NO_TRIGRAMS = 2'd2;

  // order selects for weights and query terms
  localparam logic [1:0] SEL_UNI = 2'd0;
  localparam logic [1:0] SEL_BI  = 2'd1;
  localparam logic [1:0] SEL_TRI = 2'd2;

  // ratio pairs compared during the weight walk
  localparam logic [1:0] PAIR_UB = 2'd0;
  localparam logic [1:0] PAIR_UT = 2'd1;
  localparam logic [1:0] PAIR_BT = 2'd2;

  typedef enum logic [2:0] {
    OP_LOAD_UNI = 3'd0,
    OP_LOAD_BI  = 3'd1,
    OP_LOAD_TRI = 3'd2,
    OP_COMPUTE  = 3'd3,
    OP_QUERY    = 3'd4
  } opcode_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_LU_RD,
    S_LU_WR,
    S_LOAD_WR,
    S_FINISH,
    S_CW_INIT,
    S_CW_RD_TRI,
    S_CW_CHK,
    S_CW_RD_BC,
    S_CW_RD_U2,
    S_CW_RD_U3,
    S_CW_RATIO,
    S_CW_CMP_INIT,
    S_CW_CMP,
    S_CW_TALLY,
    S_CW_W_INIT,
    S_CW_W_DIVINIT,
    S_CW_W_DONE,
    S_Q_RD,
    S_Q_MUL_INIT,
    S_Q_DIV_INIT,
    S_Q_TERM_DONE,
    S_Q_SUM,
    S_Q_NORM,
    S_Q_SQ_INIT,
    S_Q_SQ_DONE,
    S_Q_LN_INIT,
    S_Q_LN_DONE,
    S_MUL,
    S_DIV
  } state_t;

endpackage

[hw/rtl/trigram_interpolated_log_prob_core.sv]
// Trigram tag model with deleted-interpolation smoothing. Unigram, bigram and trigram counts
// live in three on-chip memories; after reset a clearing pass writes zeros through them, one
// trigram address a cycle, and no transaction is taken until it ends. Every transaction returns
// one result. Bigram and trigram loads write the count directly; unigram loads read the old
// count back to keep the corpus total. A query has three terms, each a bit-serial multiply over
// the 17 weight bits and a one-bit-per-cycle restoring divide over the 65-bit dividend, then
// normalisation and 20 squarings for log2, each a pass of the shared shift-add multiplier.
// A compute walks the whole trigram memory, with three bit-serial cross multiplications of the
// leave-one-out ratios for each nonzero trigram, then restoring divides for the three weights.
// The next transaction is accepted while a finished result waits at the output.
module trigram_interpolated_log_prob_core #(
  parameter int NUM_TAGS   = tilp_pkg::TILP_NUM_TAGS,
  parameter int COUNT_BITS = tilp_pkg::TILP_COUNT_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         opcode,
  input  logic [4:0]         tag_first,
  input  logic [4:0]         tag_second,
  input  logic [4:0]         tag_third,
  input  logic [31:0]        count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [21:0] log_prob,
  output logic [16:0]        weight_uni,
  output logic [16:0]        weight_bi,
  output logic [16:0]        weight_tri,
  output logic [1:0]         status
);
  import tilp_pkg::*;

  localparam int TB    = $clog2(NUM_TAGS);
  localparam int TW    = (TB > 5) ? TB : 5;
  localparam int CB    = COUNT_BITS;
  localparam int TOT   = CB + TB;
  localparam int TAL   = CB + 3 * TB;
  localparam int DIVW  = TAL;
  localparam int XW    = CB + LAMBDA_BITS;
  localparam int DVW   = (CB + 33 > TAL + 17) ? CB + 33 : TAL + 17;
  localparam int AW    = CB + TOT + 2;
  localparam int DCW   = $clog2(DVW + 1);
  localparam int CCW   = $clog2(TOT + 1);
  localparam int UNI_D = 1 << TB;
  localparam int BI_D  = 1 << (2 * TB);
  localparam int TRI_D = 1 << (3 * TB);

  function automatic logic tag_ok(input logic [4:0] t);
    return (TW + 1)'(t) < (TW + 1)'(NUM_TAGS);
  endfunction

  function automatic logic [TB-1:0] tag_idx(input logic [4:0] t);
    logic [TW-1:0] e;
    e = TW'(t);
    return e[TB-1:0];
  endfunction

  state_t state, state_next, mul_ret, div_ret;

  logic [2:0]        op_r;
  logic [4:0]        t1, t2, t3;
  logic [CB-1:0]     cnt;
  logic [3*TB-1:0]   idx;
  logic [CB-1:0]     c123, c12, c23, c2;
  logic [CB-1:0]     n1, n2, n3;
  logic [TOT-1:0]    d1, d2, d3;
  logic [1:0]        cmp_sel;
  logic [TOT-1:0]    sa, sb;
  logic signed [AW-1:0] cacc;
  logic [CCW-1:0]    ccnt;
  logic [2:0]        gt, lt;
  logic [TAL-1:0]    fu, fb, ft, wtot;
  logic [1:0]        wsel, tsel;
  logic [31:0]       mplr, mcand;
  logic [63:0]       macc;
  logic [5:0]        mcnt;
  logic [DVW-1:0]    dv;
  logic [DIVW-1:0]   den, rem;
  logic [31:0]       quo;
  logic              qsat;
  logic [DCW-1:0]    dcnt;
  logic [34:0]       psum;
  logic [32:0]       nrm;
  logic [5:0]        k;
  logic [31:0]       msq;
  logic [FRAC_BITS-1:0] frac;
  logic [4:0]        fcnt;
  logic [TOT-1:0]    corpus_total;
  logic [16:0]       lambda_uni, lambda_bi, lambda_tri;
  logic [21:0]       res_log;
  logic [1:0]        res_status;

  // memories
  logic [CB-1:0] uni_mem [UNI_D];
  logic [CB-1:0] bi_mem  [BI_D];
  logic [CB-1:0] tri_mem [TRI_D];
  logic [CB-1:0] uni_rdata, bi_rdata, tri_rdata, uni_wdata, bi_wdata, tri_wdata;
  logic          uni_we, bi_we, tri_we;
  logic [TB-1:0]   uni_waddr, uni_raddr;
  logic [2*TB-1:0] bi_waddr, bi_raddr;
  logic [3*TB-1:0] tri_waddr, tri_raddr;

  always_ff @(posedge clk) begin
    if (uni_we) uni_mem[uni_waddr] <= uni_wdata;
    uni_rdata <= uni_mem[uni_raddr];
  end

  always_ff @(posedge clk) begin
    if (bi_we) bi_mem[bi_waddr] <= bi_wdata;
    bi_rdata <= bi_mem[bi_raddr];
  end

  always_ff @(posedge clk) begin
    if (tri_we) tri_mem[tri_waddr] <= tri_wdata;
    tri_rdata <= tri_mem[tri_raddr];
  end

  logic acc_in, out_free, ok1, ok2, ok3, idx_last;
  logic [TB-1:0] t1i, t2i, t3i, wa, wb, wc;

  assign acc_in   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign ok1      = tag_ok(t1);
  assign ok2      = tag_ok(t2);
  assign ok3      = tag_ok(t3);
  assign t1i      = tag_idx(t1);
  assign t2i      = tag_idx(t2);
  assign t3i      = tag_idx(t3);
  assign wa       = idx[3*TB-1:2*TB];
  assign wb       = idx[2*TB-1:TB];
  assign wc       = idx[TB-1:0];
  assign idx_last = (idx == {(3*TB){1'b1}});

  // leave-one-out ratios, a zero divisor gives 0/1
  logic [CB-1:0]  d3raw, n2raw, d2raw, n1raw;
  logic [TOT-1:0] d1raw;
  always_comb begin
    d3raw = (c12 >= CB'(2)) ? c12 - CB'(1) : '0;
    n2raw = (c23 != '0) ? c23 - CB'(1) : '0;
    d2raw = (c2 >= CB'(2)) ? c2 - CB'(1) : '0;
    n1raw = (uni_rdata != '0) ? uni_rdata - CB'(1) : '0;
    d1raw = (corpus_total >= TOT'(2)) ? corpus_total - TOT'(1) : '0;
  end

  // serial cross multiplication: sign of nA*dB - nB*dA, one divisor bit a cycle
  logic [CB-1:0]  na, nb;
  logic [TOT-1:0] da, db;
  logic signed [AW-1:0] cacc_next, na_ext, nb_ext;
  always_comb begin
    unique case (cmp_sel)
      PAIR_UB: begin na = n1; da = d1; nb = n2; db = d2; end
      PAIR_UT: begin na = n1; da = d1; nb = n3; db = d3; end
      default: begin na = n2; da = d2; nb = n3; db = d3; end
    endcase
    na_ext    = $signed(AW'(na));
    nb_ext    = $signed(AW'(nb));
    cacc_next = (cacc <<< 1) + (sb[TOT-1] ? na_ext : '0) - (sa[TOT-1] ? nb_ext : '0);
  end

  logic [TAL-1:0] tsum, f_sel;
  assign tsum = fu + fb + ft;
  always_comb begin
    unique case (wsel)
      SEL_UNI: f_sel = fu;
      SEL_BI:  f_sel = fb;
      default: f_sel = ft;
    endcase
  end

  // shift-add multiplier step
  logic [63:0] macc_next;
  assign macc_next = {macc[62:0], 1'b0} + (mplr[31] ? {32'b0, mcand} : 64'b0);

  // restoring divider step
  logic [DIVW:0]   rsh;
  logic            dge;
  logic [DIVW-1:0] rem_next;
  always_comb begin
    rsh      = {rem, dv[DVW-1]};
    dge      = rsh >= {1'b0, den};
    rem_next = dge ? DIVW'(rsh - {1'b0, den}) : rsh[DIVW-1:0];
  end

  // query term operands with out-of-range tags reading as zero
  logic [CB-1:0]  q_num;
  logic [TOT-1:0] q_den;
  logic [16:0]    q_lam;
  always_comb begin
    unique case (tsel)
      SEL_UNI: begin
        q_num = ok3 ? uni_rdata : '0;
        q_den = corpus_total;
        q_lam = lambda_uni;
      end
      SEL_BI: begin
        q_num = (ok2 && ok3) ? bi_rdata : '0;
        q_den = ok2 ? TOT'(uni_rdata) : '0;
        q_lam = lambda_bi;
      end
      default: begin
        q_num = (ok1 && ok2 && ok3) ? tri_rdata : '0;
        q_den = (ok1 && ok2) ? TOT'(bi_rdata) : '0;
        q_lam = lambda_tri;
      end
    endcase
  end

  logic [32:0] p_clamp, sq_v;
  logic [MAG_BITS-1:0] mag;
  logic [63:0] ln_round;
  logic [17:0] w_round;
  always_comb begin
    p_clamp  = (psum > 35'(ONE_Q32)) ? ONE_Q32 : psum[32:0];
    sq_v     = macc[63:31];
    mag      = {k, {FRAC_BITS{1'b0}}} - MAG_BITS'(frac);
    ln_round = macc + (64'd1 << 35);
    w_round  = (18'(quo[17:0]) + 18'd1) >> 1;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:   if (idx_last) state_next = S_IDLE;
      S_IDLE: begin
        if (acc_in) begin
          unique case (opcode)
            OP_LOAD_UNI: state_next = S_LU_RD;
            OP_LOAD_BI:  state_next = S_LOAD_WR;
            OP_LOAD_TRI: state_next = S_LOAD_WR;
            OP_COMPUTE:  state_next = S_CW_INIT;
            OP_QUERY:    state_next = S_Q_RD;
            default:     state_next = S_FINISH;
          endcase
        end
      end
      S_LU_RD:       state_next = S_LU_WR;
      S_LU_WR:       state_next = S_FINISH;
      S_LOAD_WR:     state_next = S_FINISH;
      S_FINISH:      if (out_free) state_next = S_IDLE;
      S_CW_INIT:     state_next = S_CW_RD_TRI;
      S_CW_RD_TRI:   state_next = S_CW_CHK;
      S_CW_CHK: begin
        priority if (tri_rdata != '0) state_next = S_CW_RD_BC;
        else if (idx_last)            state_next = S_CW_W_INIT;
        else                          state_next = S_CW_RD_TRI;
      end
      S_CW_RD_BC:    state_next = S_CW_RD_U2;
      S_CW_RD_U2:    state_next = S_CW_RD_U3;
      S_CW_RD_U3:    state_next = S_CW_RATIO;
      S_CW_RATIO:    state_next = S_CW_CMP_INIT;
      S_CW_CMP_INIT: state_next = S_CW_CMP;
      S_CW_CMP: begin
        if (ccnt == CCW'(1))
          state_next = (cmp_sel == PAIR_BT) ? S_CW_TALLY : S_CW_CMP_INIT;
      end
      S_CW_TALLY:     state_next = idx_last ? S_CW_W_INIT : S_CW_RD_TRI;
      S_CW_W_INIT:    state_next = (tsum == '0) ? S_FINISH : S_CW_W_DIVINIT;
      S_CW_W_DIVINIT: state_next = S_DIV;
      S_CW_W_DONE:    state_next = (wsel == SEL_TRI) ? S_FINISH : S_CW_W_DIVINIT;
      S_Q_RD:         state_next = S_Q_MUL_INIT;
      S_Q_MUL_INIT:   state_next = (q_den == '0) ? S_Q_TERM_DONE : S_MUL;
      S_Q_DIV_INIT:   state_next = S_DIV;
      S_Q_TERM_DONE:  state_next = (tsel == SEL_TRI) ? S_Q_SUM : S_Q_RD;
      S_Q_SUM:        state_next = (p_clamp == '0) ? S_FINISH : S_Q_NORM;
      S_Q_NORM:       if (nrm[32]) state_next = S_Q_SQ_INIT;
      S_Q_SQ_INIT:    state_next = S_MUL;
      S_Q_SQ_DONE:
        state_next = (fcnt == 5'(FRAC_BITS - 1)) ? S_Q_LN_INIT : S_Q_SQ_INIT;
      S_Q_LN_INIT:    state_next = S_MUL;
      S_Q_LN_DONE:    state_next = S_FINISH;
      S_MUL:          if (mcnt == 6'd1) state_next = mul_ret;
      S_DIV:          if (dcnt == DCW'(1)) state_next = div_ret;
      default:        state_next = S_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    in_ready  = (state == S_IDLE);
    uni_we    = 1'b0;
    bi_we     = 1'b0;
    tri_we    = 1'b0;
    uni_waddr = t3i;
    bi_waddr  = {t2i, t3i};
    tri_waddr = {t1i, t2i, t3i};
    uni_wdata = cnt;
    bi_wdata  = cnt;
    tri_wdata = cnt;
    uni_raddr = '0;
    bi_raddr  = '0;
    tri_raddr = '0;
    unique case (state)
      S_CLEAR: begin
        uni_we    = 1'b1;
        bi_we     = 1'b1;
        tri_we    = 1'b1;
        uni_waddr = wc;
        bi_waddr  = {wb, wc};
        tri_waddr = idx;
        uni_wdata = '0;
        bi_wdata  = '0;
        tri_wdata = '0;
      end
      S_LU_RD: uni_raddr = t3i;
      S_LU_WR: uni_we = ok3;
      S_LOAD_WR: begin
        if (op_r == OP_LOAD_BI) bi_we = ok2 && ok3;
        else                    tri_we = ok1 && ok2 && ok3;
      end
      S_CW_RD_TRI: tri_raddr = idx;
      S_CW_CHK:    bi_raddr  = {wa, wb};
      S_CW_RD_BC:  bi_raddr  = {wb, wc};
      S_CW_RD_U2:  uni_raddr = wb;
      S_CW_RD_U3:  uni_raddr = wc;
      S_Q_RD: begin
        unique case (tsel)
          SEL_UNI: uni_raddr = t3i;
          SEL_BI: begin
            bi_raddr  = {t2i, t3i};
            uni_raddr = t2i;
          end
          default: begin
            tri_raddr = {t1i, t2i, t3i};
            bi_raddr  = {t1i, t2i};
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      log_prob   <= $signed(res_log);
      weight_uni <= lambda_uni;
      weight_bi  <= lambda_bi;
      weight_tri <= lambda_tri;
      status     <= res_status;
    end
  end

  // model state that reset clears
  always_ff @(posedge clk) begin
    if (rst) begin
      idx          <= '0;
      corpus_total <= '0;
      lambda_uni   <= '0;
      lambda_bi    <= '0;
      lambda_tri   <= '0;
    end else begin
      unique case (state)
        S_CLEAR:    idx <= idx + 1'b1;
        S_CW_INIT:  idx <= '0;
        S_CW_CHK:   if (tri_rdata == '0) idx <= idx + 1'b1;
        S_CW_TALLY: idx <= idx + 1'b1;
        S_LU_WR: begin
          if (ok3) corpus_total <= corpus_total - TOT'(uni_rdata) + TOT'(cnt);
        end
        S_CW_W_INIT: begin
          if (tsum == '0) begin
            lambda_uni <= '0;
            lambda_bi  <= '0;
            lambda_tri <= '0;
          end
        end
        S_CW_W_DONE: begin
          unique case (wsel)
            SEL_UNI: lambda_uni <= w_round[16:0];
            SEL_BI:  lambda_bi  <= w_round[16:0];
            default: lambda_tri <= w_round[16:0];
          endcase
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (acc_in) begin
          op_r       <= opcode;
          t1         <= tag_first;
          t2         <= tag_second;
          t3         <= tag_third;
          cnt        <= count[CB-1:0];
          res_log    <= '0;
          res_status <= ST_OK;
          tsel       <= SEL_UNI;
          psum       <= '0;
        end
      end
      S_CW_INIT: begin
        fu <= '0;
        fb <= '0;
        ft <= '0;
      end
      S_CW_CHK:   c123 <= tri_rdata;
      S_CW_RD_BC: c12  <= bi_rdata;
      S_CW_RD_U2: c23  <= bi_rdata;
      S_CW_RD_U3: c2   <= uni_rdata;
      S_CW_RATIO: begin
        if (d3raw == '0) begin
          n3 <= '0;
          d3 <= TOT'(1);
        end else begin
          n3 <= c123 - CB'(1);
          d3 <= TOT'(d3raw);
        end
        if (d2raw == '0) begin
          n2 <= '0;
          d2 <= TOT'(1);
        end else begin
          n2 <= n2raw;
          d2 <= TOT'(d2raw);
        end
        if (d1raw == '0) begin
          n1 <= '0;
          d1 <= TOT'(1);
        end else begin
          n1 <= n1raw;
          d1 <= d1raw;
        end
        cmp_sel <= PAIR_UB;
      end
      S_CW_CMP_INIT: begin
        sa   <= da;
        sb   <= db;
        cacc <= '0;
        ccnt <= CCW'(TOT);
      end
      S_CW_CMP: begin
        sa   <= sa << 1;
        sb   <= sb << 1;
        cacc <= cacc_next;
        ccnt <= ccnt - CCW'(1);
        if (ccnt == CCW'(1)) begin
          gt[cmp_sel] <= (cacc_next > 0);
          lt[cmp_sel] <= cacc_next[AW-1];
          cmp_sel     <= cmp_sel + 2'd1;
        end
      end
      S_CW_TALLY: begin
        // ties fall to the trigram
        priority if (gt[PAIR_UB] && gt[PAIR_UT]) fu <= fu + TAL'(c123);
        else if (lt[PAIR_UB] && gt[PAIR_BT])     fb <= fb + TAL'(c123);
        else                                     ft <= ft + TAL'(c123);
      end
      S_CW_W_INIT: begin
        wtot <= tsum;
        wsel <= SEL_UNI;
        if (tsum == '0) res_status <= ST_NO_TRIGRAMS;
      end
      S_CW_W_DIVINIT: begin
        dv      <= DVW'(f_sel) << 17;
        den     <= wtot;
        rem     <= '0;
        quo     <= '0;
        qsat    <= 1'b0;
        dcnt    <= DCW'(DVW);
        div_ret <= S_CW_W_DONE;
      end
      S_CW_W_DONE: wsel <= wsel + 2'd1;
      S_Q_MUL_INIT: begin
        den     <= DIVW'(q_den);
        mplr    <= {q_lam, {(32 - LAMBDA_BITS){1'b0}}};
        mcand   <= 32'(q_num);
        macc    <= '0;
        mcnt    <= 6'(LAMBDA_BITS);
        mul_ret <= S_Q_DIV_INIT;
        quo     <= '0;
        qsat    <= 1'b0;
      end
      S_Q_DIV_INIT: begin
        dv      <= DVW'(macc[XW-1:0]) << 16;
        rem     <= '0;
        quo     <= '0;
        qsat    <= 1'b0;
        dcnt    <= DCW'(DVW);
        div_ret <= S_Q_TERM_DONE;
      end
      S_Q_TERM_DONE: begin
        psum <= psum + (qsat ? 35'(ONE_Q32) : 35'(quo));
        tsel <= tsel + 2'd1;
      end
      S_Q_SUM: begin
        nrm <= p_clamp;
        k   <= '0;
        if (p_clamp == '0) begin
          res_log    <= 22'd0 - LOG_MIN;
          res_status <= ST_ZERO_PROB;
        end
      end
      S_Q_NORM: begin
        if (nrm[32]) begin
          msq  <= nrm[32:1];
          frac <= '0;
          fcnt <= '0;
        end else begin
          nrm <= nrm << 1;
          k   <= k + 6'd1;
        end
      end
      S_Q_SQ_INIT: begin
        mplr    <= msq;
        mcand   <= msq;
        macc    <= '0;
        mcnt    <= 6'd32;
        mul_ret <= S_Q_SQ_DONE;
      end
      S_Q_SQ_DONE: begin
        // square at or above two gives a one bit and a halving
        frac <= {frac[FRAC_BITS-2:0], sq_v[32]};
        msq  <= sq_v[32] ? sq_v[32:1] : sq_v[31:0];
        fcnt <= fcnt + 5'd1;
      end
      S_Q_LN_INIT: begin
        mplr    <= {mag, {(32 - MAG_BITS){1'b0}}};
        mcand   <= LN2_Q32;
        macc    <= '0;
        mcnt    <= 6'(MAG_BITS);
        mul_ret <= S_Q_LN_DONE;
      end
      S_Q_LN_DONE: res_log <= 22'd0 - ln_round[57:36];
      S_MUL: begin
        macc <= macc_next;
        mplr <= mplr << 1;
        mcnt <= mcnt - 6'd1;
      end
      S_DIV: begin
        rem  <= rem_next;
        dv   <= dv << 1;
        quo  <= {quo[30:0], dge};
        qsat <= qsat | quo[31];
        dcnt <= dcnt - DCW'(1);
      end
      default: ;
    endcase
  end

endmodule
